// File: rtl/uttok_pkg.sv
// ----------------------------------------------------------------------------
// uttok_pkg
// Shared types, constants and byte-class functions of the UTF-8 tag span
// tokenizer.
// ----------------------------------------------------------------------------
package uttok_pkg;

    // Fixed field widths of the item ports.
    localparam int BYTE_W  = 8;
    localparam int START_W = 16;
    localparam int LEN_W   = 6;
    localparam int CNT_W   = 16;

    // Defaults of the top-level parameters.
    localparam int MAX_TAG_DEF   = 32;
    localparam int MAX_TEXT_DEF  = 65536;
    localparam int CMDQ_DEPTH_DEF = 4;

    // Reset value of the span limit register.
    localparam logic [CNT_W-1:0] MAX_SPANS_RESET = 16'hFFFF;

    // Characters that drive the tag recognizer.
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_LT    = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_GT    = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;

    // Tag recognizer phase, one-hot.
    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_OPEN  = 4'b0010,
        PH_SLASH = 4'b0100,
        PH_NAME  = 4'b1000
    } phase_t;

    // Work handed from the front to the back: a run of one-byte spans for
    // the bytes of a broken tag, then optionally one further span.
    typedef struct packed {
        logic [START_W-1:0] flush_start;
        logic [LEN_W-1:0]   flush_n;
        logic               extra_v;
        logic [START_W-1:0] extra_start;
        logic [LEN_W-1:0]   extra_len;
    } cmd_t;

    // Length of a character from its UTF-8 lead byte; invalid leads count one.
    function automatic logic [2:0] lead_length(input logic [BYTE_W-1:0] b);
        logic [2:0] len;
        if ((b & 8'h80) == 8'h00)      len = 3'd1;
        else if ((b & 8'hE0) == 8'hC0) len = 3'd2;
        else if ((b & 8'hF0) == 8'hE0) len = 3'd3;
        else if ((b & 8'hF8) == 8'hF0) len = 3'd4;
        else                           len = 3'd1;
        return len;
    endfunction

    // Upper-case letters and digits may form a tag name.
    function automatic logic is_name_char(input logic [BYTE_W-1:0] b);
        return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h30) && (b <= 8'h39));
    endfunction

endpackage

// File: rtl/uttok_front.sv
// ----------------------------------------------------------------------------
// uttok_front
// Takes one text byte per cycle, tracks position, span count, continuation
// bytes and the tag recognizer, and issues span work to the command queue.
// ----------------------------------------------------------------------------
module uttok_front #(
    parameter int MAX_TAG  = uttok_pkg::MAX_TAG_DEF,
    parameter int MAX_TEXT = uttok_pkg::MAX_TEXT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [uttok_pkg::BYTE_W-1:0]    text_byte,
    input  logic                            cfg_we,
    input  logic [uttok_pkg::CNT_W-1:0]     cfg_wdata,
    output logic                            cmd_push,
    output uttok_pkg::cmd_t                 cmd
);
    import uttok_pkg::*;

    localparam int POS_W = $clog2(MAX_TEXT + 1);

    logic [CNT_W-1:0] max_reg,   max_next;
    logic [POS_W-1:0] pos_reg,   pos_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic [POS_W-1:0] tstart_reg, tstart_next;
    logic [LEN_W-1:0] tlen_reg,  tlen_next;
    phase_t           phase_reg, phase_next;
    logic [1:0]       cont_reg,  cont_next;

    // Decode of one accepted byte.
    always_comb
    begin
        logic             flush_req;
        logic             idle_req;
        logic             extra_req;
        logic             ok;
        phase_t           ok_phase;
        logic [LEN_W:0]   tlen_ext;
        logic [2:0]       llen;
        logic [START_W-1:0] x_start;
        logic [LEN_W-1:0] x_len;
        logic [CNT_W-1:0] rem;
        logic [LEN_W-1:0] nf;
        logic [CNT_W-1:0] cnt_after;
        logic             x_ok;

        max_next    = cfg_we ? cfg_wdata : max_reg;
        pos_next    = pos_reg;
        cnt_next    = cnt_reg;
        tstart_next = tstart_reg;
        tlen_next   = tlen_reg;
        phase_next  = phase_reg;
        cont_next   = cont_reg;

        flush_req = 1'b0;
        idle_req  = 1'b0;
        extra_req = 1'b0;
        ok        = 1'b0;
        ok_phase  = PH_IDLE;
        tlen_ext  = {1'b0, tlen_reg};
        llen      = lead_length(text_byte);
        x_start   = START_W'(pos_reg);
        x_len     = LEN_W'(llen);

        if (accept) begin
            if (text_byte == CH_NUL) begin
                flush_req = (phase_reg != PH_IDLE);
            end else if ((pos_reg < POS_W'(MAX_TEXT)) && (cnt_reg < max_reg)) begin
                pos_next = pos_reg + POS_W'(1);
                if (cont_reg != 2'd0) begin
                    cont_next = cont_reg - 2'd1;
                end else if (phase_reg == PH_IDLE) begin
                    idle_req = 1'b1;
                end else begin
                    // Tag in progress: close, extend or break.
                    if ((phase_reg == PH_NAME) && (text_byte == CH_GT)) begin
                        ok = 1'b0;
                    end else if ((phase_reg == PH_OPEN) && (text_byte == CH_SLASH)) begin
                        ok       = 1'b1;
                        ok_phase = PH_SLASH;
                    end else if (is_name_char(text_byte)) begin
                        ok       = 1'b1;
                        ok_phase = PH_NAME;
                    end
                    if ((phase_reg == PH_NAME) && (text_byte == CH_GT)
                        && (tlen_ext + 7'd1 <= 7'(MAX_TAG))) begin
                        extra_req  = 1'b1;
                        x_start    = START_W'(tstart_reg);
                        x_len      = tlen_reg + LEN_W'(1);
                        phase_next = PH_IDLE;
                        tlen_next  = '0;
                    end else if (ok && (tlen_ext + 7'd2 <= 7'(MAX_TAG))) begin
                        tlen_next  = tlen_reg + LEN_W'(1);
                        phase_next = ok_phase;
                    end else begin
                        flush_req = 1'b1;
                        idle_req  = 1'b1;
                    end
                end
            end
        end

        // A broken tag returns the recognizer to idle before the byte is redone.
        if (flush_req) begin
            phase_next = PH_IDLE;
            tlen_next  = '0;
        end

        // Idle handling: a tag opens or a character span is issued.
        if (idle_req) begin
            if (text_byte == CH_LT) begin
                phase_next  = PH_OPEN;
                tstart_next = pos_reg;
                tlen_next   = LEN_W'(1);
            end else begin
                extra_req = 1'b1;
                x_start   = START_W'(pos_reg);
                x_len     = LEN_W'(llen);
                cont_next = llen[1:0] - 2'd1;
            end
        end

        // Span limit applied to the flush run and the further span.
        rem       = (cnt_reg < max_reg) ? (max_reg - cnt_reg) : '0;
        nf        = '0;
        if (flush_req) begin
            nf = (rem < CNT_W'(tlen_reg)) ? rem[LEN_W-1:0] : tlen_reg;
        end
        cnt_after = cnt_reg + CNT_W'(nf);
        x_ok      = extra_req && (cnt_after < max_reg);
        cnt_next  = accept ? (cnt_after + CNT_W'(x_ok)) : cnt_reg;

        // The terminator starts a fresh text.
        if (accept && (text_byte == CH_NUL)) begin
            pos_next    = '0;
            cnt_next    = '0;
            tstart_next = '0;
            tlen_next   = '0;
            phase_next  = PH_IDLE;
            cont_next   = '0;
        end

        cmd.flush_start = START_W'(tstart_reg);
        cmd.flush_n     = nf;
        cmd.extra_v     = x_ok;
        cmd.extra_start = x_start;
        cmd.extra_len   = x_len;
        cmd_push        = accept && ((nf != '0) || x_ok);
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_reg    <= MAX_SPANS_RESET;
            pos_reg    <= '0;
            cnt_reg    <= '0;
            tstart_reg <= '0;
            tlen_reg   <= '0;
            phase_reg  <= PH_IDLE;
            cont_reg   <= '0;
        end else begin
            max_reg    <= max_next;
            pos_reg    <= pos_next;
            cnt_reg    <= cnt_next;
            tstart_reg <= tstart_next;
            tlen_reg   <= tlen_next;
            phase_reg  <= phase_next;
            cont_reg   <= cont_next;
        end
    end

endmodule

// File: rtl/uttok_cmd_fifo.sv
// ----------------------------------------------------------------------------
// uttok_cmd_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module uttok_cmd_fifo #(
    parameter int DEPTH = uttok_pkg::CMDQ_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  uttok_pkg::cmd_t push_data,
    input  logic            pop,
    output uttok_pkg::cmd_t head,
    output logic            full,
    output logic            empty
);
    import uttok_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W_Q = $clog2(DEPTH + 1);

    cmd_t               store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W_Q-1:0] count_reg,  count_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == CNT_W_Q'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = store_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W_Q'(do_push) - CNT_W_Q'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; no reset needed.
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/uttok_back.sv
// ----------------------------------------------------------------------------
// uttok_back
// Expands queued commands into spans in the result register, one span per
// cycle while the result register is empty or popped.
// ----------------------------------------------------------------------------
module uttok_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    input  uttok_pkg::cmd_t                q_head,
    output logic                           q_pop,
    input  logic                           pop,
    output logic                           empty,
    output logic [uttok_pkg::START_W-1:0]  span_start,
    output logic [uttok_pkg::LEN_W-1:0]    span_length,
    output logic                           last_of_run
);
    import uttok_pkg::*;

    logic               work_v_reg, work_v_next;
    cmd_t               work_reg,   work_next;
    logic               out_v_reg,  out_v_next;
    logic [START_W-1:0] start_reg,  start_next;
    logic [LEN_W-1:0]   len_reg,    len_next;
    logic               last_reg,   last_next;
    logic               adv;
    logic               emit;
    logic               finishing;

    assign adv  = !out_v_reg || pop;
    assign emit = work_v_reg && adv;

    // Span generation and command loading.
    always_comb
    begin
        work_next  = work_reg;
        start_next = start_reg;
        len_next   = len_reg;
        last_next  = last_reg;
        finishing  = 1'b0;

        if (emit) begin
            if (work_reg.flush_n != '0) begin
                start_next           = work_reg.flush_start;
                len_next             = LEN_W'(1);
                finishing            = (work_reg.flush_n == LEN_W'(1)) && !work_reg.extra_v;
                last_next            = finishing;
                work_next.flush_start = work_reg.flush_start + START_W'(1);
                work_next.flush_n    = work_reg.flush_n - LEN_W'(1);
            end else begin
                start_next        = work_reg.extra_start;
                len_next          = work_reg.extra_len;
                last_next         = 1'b1;
                finishing         = 1'b1;
                work_next.extra_v = 1'b0;
            end
        end

        q_pop = !q_empty && (!work_v_reg || (emit && finishing));
        if (q_pop) begin
            work_next = q_head;
        end

        work_v_next = q_pop ? 1'b1 : ((emit && finishing) ? 1'b0 : work_v_reg);
        out_v_next  = emit ? 1'b1 : (pop ? 1'b0 : out_v_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            work_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end else begin
            work_v_reg <= work_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        work_reg  <= work_next;
        start_reg <= start_next;
        len_reg   <= len_next;
        last_reg  <= last_next;
    end

    assign empty       = !out_v_reg;
    assign span_start  = start_reg;
    assign span_length = len_reg;
    assign last_of_run = last_reg;

endmodule

// File: rtl/utf8_tag_span_tokenizer_top.sv
// ----------------------------------------------------------------------------
// utf8_tag_span_tokenizer_top
// Splits a UTF-8 byte stream into character and tag spans given as start
// offset and length.
//
//  Channel   | Handshake      | Payload
//  ----------+----------------+------------------------------------------
//  input     | push / full    | text_byte
//  result    | pop / empty    | span_start, span_length, last_of_run
//  config    | cfg_we         | cfg_wdata (max_spans)
//
// The front takes one byte per cycle while the command queue has room.
// The back delivers one span per cycle unless the result waits unpopped;
// a broken tag of n pending bytes yields up to n+1 spans, and the input
// stalls once the queue fills. A result passes queue, work and result regs.
// Reset clears all control state and sets max_spans to 65535.
// ----------------------------------------------------------------------------
module utf8_tag_span_tokenizer_top #(
    parameter int MAX_TAG    = uttok_pkg::MAX_TAG_DEF,
    parameter int MAX_TEXT   = uttok_pkg::MAX_TEXT_DEF,
    parameter int CMDQ_DEPTH = uttok_pkg::CMDQ_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [uttok_pkg::BYTE_W-1:0]   text_byte,
    input  logic                           pop,
    output logic                           empty,
    output logic [uttok_pkg::START_W-1:0]  span_start,
    output logic [uttok_pkg::LEN_W-1:0]    span_length,
    output logic                           last_of_run,
    input  logic                           cfg_we,
    input  logic [uttok_pkg::CNT_W-1:0]    cfg_wdata
);
    import uttok_pkg::*;

    logic accept;
    logic cmd_push;
    cmd_t cmd;
    logic cmd_pop;
    cmd_t cmd_head;
    logic cmd_empty;

    assign accept = push && !full;

    // Front: classify each byte and issue span work.
    uttok_front #(
        .MAX_TAG  (MAX_TAG),
        .MAX_TEXT (MAX_TEXT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .text_byte (text_byte),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_push  (cmd_push),
        .cmd       (cmd)
    );

    // Command queue decoupling front and back.
    uttok_cmd_fifo #(
        .DEPTH (CMDQ_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd),
        .pop       (cmd_pop),
        .head      (cmd_head),
        .full      (full),
        .empty     (cmd_empty)
    );

    // Back: expand commands into spans.
    uttok_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (cmd_empty),
        .q_head      (cmd_head),
        .q_pop       (cmd_pop),
        .pop         (pop),
        .empty       (empty),
        .span_start  (span_start),
        .span_length (span_length),
        .last_of_run (last_of_run)
    );

    // A waiting span always has a length between one and the tag limit.
    a_span_len: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((span_length != '0) && (span_length <= LEN_W'(MAX_TAG))))
        else $error("span length out of range");

    // The front never queues a command that yields no span.
    a_cmd_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> ((cmd.flush_n != '0) || cmd.extra_v))
        else $error("empty command queued");

    // A flush run never exceeds the bytes a tag can hold while still open.
    a_flush_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> (cmd.flush_n <= LEN_W'(MAX_TAG - 1)))
        else $error("flush run too long");

endmodule
